/* src/fpba_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpba_pkg: shared types, constants and fp16 helpers
// Holds the command codes, the register indexes and the bias add arithmetic.
// ---------------------------------------------------------------------------
package fpba_pkg;

   localparam int unsigned MaxChannelsDefault = 1024;
   localparam logic [15:0] ClipReset = 16'h4600;
   localparam logic [15:0] DefaultNan = 16'h7E00;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DATA = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_RELU = 2'd1,
      ACT_CLIP = 2'd2,
      ACT_RSVD = 2'd3
   } activation_type;

   typedef enum logic [1:0] {
      REG_ACT_MODE = 2'd0,
      REG_CLIP     = 2'd1,
      REG_CHANNELS = 2'd2,
      REG_UNUSED   = 2'd3
   } reg_type;

   // data item handed from front to back
   typedef struct packed {
      logic [15:0] value;
      logic        last;
   } item_type;

   // special case flags computed in the first back stage
   typedef struct packed {
      logic        special;
      logic [15:0] special_val;
      logic        zero;
      logic [15:0] zero_val;
      logic        sign;
      logic [41:0] mag;
   } sum_type;

   function automatic logic is_nan(input logic [15:0] h);
      is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
   endfunction

   function automatic logic [41:0] mag_of(input logic [15:0] h);
      logic [41:0] m;
      m = {31'd0, (h[14:10] != 5'd0), h[9:0]};
      if (h[14:10] != 5'd0) m = m << (h[14:10] - 5'd1);
      mag_of = m;
   endfunction

   // exact sum, signed magnitude form, with special results resolved
   function automatic sum_type fp_sum(input logic [15:0] a, input logic [15:0] b);
      sum_type s;
      logic ia, ib;
      logic [41:0] ma, mb;
      ia = a[14:0] == 15'h7C00;
      ib = b[14:0] == 15'h7C00;
      ma = mag_of(a);
      mb = mag_of(b);
      s.special = 1'b1;
      s.special_val = a;
      s.zero = 1'b0;
      s.zero_val = {a[15] & b[15], 15'd0};
      s.sign = a[15];
      s.mag = 42'd0;
      if (is_nan(a)) s.special_val = a | 16'h0200;
      else if (is_nan(b)) s.special_val = b | 16'h0200;
      else if (ia && ib) s.special_val = (a[15] == b[15]) ? a : DefaultNan;
      else if (ia) s.special_val = a;
      else if (ib) s.special_val = b;
      else begin
         s.special = 1'b0;
         if (a[15] == b[15]) s.mag = ma + mb;
         else if (ma >= mb) s.mag = ma - mb;
         else begin
            s.mag = mb - ma;
            s.sign = b[15];
         end
         s.zero = s.mag == 42'd0;
      end
      fp_sum = s;
   endfunction

   // round nonzero magnitude (units of 2^-24) to fp16 without sign
   function automatic logic [14:0] encode_mag(input logic [41:0] mag);
      logic [5:0] p;
      logic [5:0] sh;
      logic [41:0] q, rem, half, one;
      logic [6:0] e;
      p = 6'd0;
      for (int i = 0; i < 42; i++) if (mag[i]) p = 6'(i);
      if (mag < 42'd1024) encode_mag = mag[14:0];
      else begin
         sh = p - 6'd10;
         q = mag >> sh;
         one = 42'd1 << sh;
         rem = mag & (one - 42'd1);
         half = one >> 1;
         if (sh != 6'd0) begin
            if (rem > half || (rem == half && q[0])) q = q + 42'd1;
            if (q == 42'd2048) begin
               q = q >> 1;
               sh = sh + 6'd1;
            end
         end
         e = {1'b0, sh} + 7'd1;
         if (e >= 7'd31) encode_mag = 15'h7C00;
         else encode_mag = {e[4:0], q[9:0] - 10'd0};
      end
   endfunction

   function automatic logic [15:0] order_key(input logic [15:0] h);
      order_key = h[15] ? ~{1'b0, h[14:0]} : {1'b0, h[14:0]};
   endfunction

   function automatic logic [15:0] fp_min(input logic [15:0] x, input logic [15:0] y);
      if (is_nan(x)) fp_min = x | 16'h0200;
      else if (is_nan(y)) fp_min = y | 16'h0200;
      else fp_min = ($signed(order_key(y)) < $signed(order_key(x))) ? y : x;
   endfunction

endpackage

/* src/fpba_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpba_ram: generic single port write, registered read RAM
// One write and one read address per cycle, read data registered and valid in the cycle after the read.
// ---------------------------------------------------------------------------
module fpba_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fpba_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpba_front: input classification and channel tracking
// Writes load transactions to the bias table, forwards data items with
// their channel number and end of row flag into the queue.
// ---------------------------------------------------------------------------
module fpba_front #(
   parameter int unsigned MAX_CHANNELS = fpba_pkg::MaxChannelsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,
   input  logic [10:0]                     channels,
   input  logic                            q_ready,
   output logic                            q_valid,
   output fpba_pkg::item_type              q_item,
   output logic [$clog2(MAX_CHANNELS)-1:0] q_addr,
   output logic                            ld_en,
   output logic [$clog2(MAX_CHANNELS)-1:0] ld_addr,
   output logic [15:0]                     ld_data
);
   import fpba_pkg::*;

   localparam int unsigned AW = $clog2(MAX_CHANNELS);
   localparam int unsigned CW = AW + 1;

   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] eff;
   logic          is_data, last, fire;

   assign is_data = req_tdata[0] == CMD_DATA;
   assign req_tready = q_ready;
   assign fire = req_tvalid && req_tready;

   // effective channel count, zero or above range means the full table
   always_comb begin
      if (channels == 11'd0 || 32'(channels) > 32'(MAX_CHANNELS)) eff = CW'(MAX_CHANNELS);
      else eff = CW'(channels);
   end

   assign last = ({1'b0, pos_ff} + CW'(1)) >= eff;
   assign pos_in = last ? '0 : pos_ff + AW'(1);

   // channel counter
   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else if (fire && is_data) pos_ff <= pos_in;
   end

   // bias load path, index above range ignored
   assign ld_en = fire && !is_data && (32'(req_tdata[10:1]) < 32'(MAX_CHANNELS));
   assign ld_addr = AW'(req_tdata[10:1]);
   assign ld_data = req_tdata[26:11];

   assign q_valid = fire && is_data;
   assign q_item.value = req_tdata[26:11];
   assign q_item.last = last;
   assign q_addr = pos_ff;

endmodule

/* src/fpba_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpba_back: bias add, rounding and activation pipeline
// Stage one forms the exact sum, stage two rounds and activates into the
// output register; a skid register takes a result while the sink stalls.
// ---------------------------------------------------------------------------
module fpba_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  fpba_pkg::item_type in_item,
   input  logic [15:0]        bias,
   input  logic [1:0]         act_mode,
   input  logic [15:0]        clip_value,
   output logic               pipe_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata
);
   import fpba_pkg::*;

   // stage one registers
   logic     s1_valid_ff;
   sum_type  s1_sum_ff;
   logic     s1_last_ff;
   // output and skid
   logic        o_valid_ff, k_valid_ff;
   logic [16:0] o_data_ff, k_data_ff;
   logic [15:0] r, rc;
   logic        adv;

   // pipeline advances while the skid register is free
   assign pipe_ready = !k_valid_ff;
   assign adv = pipe_ready;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= in_valid;
      if (adv) begin
         s1_sum_ff  <= fp_sum(in_item.value, bias);
         s1_last_ff <= in_item.last;
      end
   end

   // rounding and activation
   always_comb begin
      if (s1_sum_ff.special) r = s1_sum_ff.special_val;
      else if (s1_sum_ff.zero) r = s1_sum_ff.zero_val;
      else r = {s1_sum_ff.sign, encode_mag(s1_sum_ff.mag)};
      rc = r;
      if (act_mode == ACT_RELU || act_mode == ACT_CLIP) begin
         if (!is_nan(r) && r[15]) rc = 16'd0;
         if (act_mode == ACT_CLIP) rc = fp_min(rc, clip_value);
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
      end else begin
         if (!o_valid_ff || rsp_tready) begin
            if (k_valid_ff) begin
               o_valid_ff <= 1'b1;
               k_valid_ff <= 1'b0;
            end else o_valid_ff <= s1_valid_ff;
         end else if (s1_valid_ff && adv) k_valid_ff <= 1'b1;
      end
      if (!o_valid_ff || rsp_tready) o_data_ff <= k_valid_ff ? k_data_ff : {s1_last_ff, rc};
      else if (s1_valid_ff && adv) k_data_ff <= {s1_last_ff, rc};
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = {7'd0, o_data_ff};

endmodule

/* src/fp16_bias_add_activation.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fp16_bias_add_activation: fp16 per-channel bias add with relu / relu6
//
// req channel: tdata = cmd, index, value. cmd load writes the bias table at
// index and gives no result; cmd data adds the bias of the current channel
// and gives one result on the rsp channel (tdata = result, end_of_row).
// Channels are counted in arrival order and wrap at the channels register.
// One item is accepted per cycle while req_tready is high; after the edge that
// accepts a data transaction, rsp_tvalid rises once the item has passed the
// registers in order (bias RAM read, exact sum, rounded and activated output).
// The front takes items while the back's skid register is empty; when the
// sink stalls, one result waits in the output register and one in the skid,
// two more are held in the pipeline, and req_tready drops until the sink
// takes a result. The user must write registers on the csr port only while
// idle; the block does not enforce it. Reset clears the channel counter and
// loads the register defaults (no activation, clip 6.0, 1024 channels); the
// bias table is not cleared and must be loaded before use.
// ---------------------------------------------------------------------------
module fp16_bias_add_activation #(
   parameter int unsigned MAX_CHANNELS = fpba_pkg::MaxChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // cmd, index[9:0], value[15:0], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result[15:0], end_of_row, zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import fpba_pkg::*;

   localparam int unsigned AW = $clog2(MAX_CHANNELS);

   logic [1:0]  act_ff;
   logic [15:0] clip_ff;
   logic [10:0] chan_ff;
   logic        q_valid, q_ready, ld_en, d_valid_ff;
   item_type    q_item, d_item_ff;
   logic [AW-1:0] q_addr, ld_addr, rd_addr;
   logic [15:0] ld_data, bias;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= ACT_NONE;
         clip_ff <= ClipReset;
         chan_ff <= 11'd1024;
      end else if (csr_we) begin
         case (reg_type'(csr_index))
            REG_ACT_MODE: act_ff <= csr_wdata[1:0];
            REG_CLIP:     clip_ff <= csr_wdata;
            REG_CHANNELS: chan_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   fpba_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .channels(chan_ff), .q_ready, .q_valid, .q_item, .q_addr,
      .ld_en, .ld_addr, .ld_data
   );

   // queue stage: bias read issued, item held alongside
   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else if (q_ready) d_valid_ff <= q_valid;
      if (q_ready) d_item_ff <= q_item;
   end
   assign rd_addr = q_addr;

   fpba_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_bias (
      .clock, .wr_en(ld_en), .wr_addr(ld_addr), .wr_data(ld_data),
      .rd_en(q_ready), .rd_addr, .rd_data(bias)
   );

   fpba_back u_back (
      .clock, .reset, .in_valid(d_valid_ff), .in_item(d_item_ff), .bias,
      .act_mode(act_ff), .clip_value(clip_ff), .pipe_ready(q_ready),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   // held result stays while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // front never accepts while back is full
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !q_ready |-> !req_tready)
      else $error("accepted with full skid");
   // padding bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:17] == 7'd0)
      else $error("nonzero padding");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for fp16_bias_add_activation
// Loads bias entries and streams data elements in phases. Every phase runs
// under its own register setting. Each accepted data transaction is predicted
// bit for bit, covering rounding, subnormals, NaN, infinity, relu and the
// clip. Expected results are compared in order with what leaves the rsp side.
// ---------------------------------------------------------------------------
module testbench;
   import fpba_pkg::*;

   localparam int NumSlots = 1024;
   localparam int Latency = 8;
   localparam int WatchdogLimit = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   typedef struct packed {
      logic [15:0] result;
      logic        end_of_row;
   } elem_out_type;

   fp16_bias_add_activation u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock generation
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [31:0]  pending_items[$];
   elem_out_type expected_elems[$];
   int           error_count = 0;
   bit           send_pause = 1'b0;
   int           hold_requests = 0;

   // predictor state
   logic [15:0]    bias_copy[NumSlots];
   int unsigned    pos_copy = 0;
   activation_type act_copy = ACT_NONE;
   logic [15:0]    clip_copy = ClipReset;
   int unsigned    chan_copy = 1024;

   // generator's own view of slots and channel position
   bit          slot_loaded[NumSlots];
   int unsigned gen_pos = 0;

   function automatic bit h_nan(input logic [15:0] h);
      return h[14:10] == 5'h1F && h[9:0] != 0;
   endfunction

   // magnitude in 2^-24 units
   function automatic longint unsigned h_mag(input logic [15:0] h);
      longint unsigned m;
      m = h[9:0];
      if (h[14:10] != 0) m = (m + 1024) << (h[14:10] - 1);
      return m;
   endfunction

   function automatic logic [15:0] h_add(input logic [15:0] a, input logic [15:0] b);
      longint unsigned ma, mb, mag, q, rem, half;
      logic sgn;
      int p, sh;
      if (h_nan(a)) return a | 16'h0200;
      if (h_nan(b)) return b | 16'h0200;
      if (a[14:0] == 15'h7C00 && b[14:0] == 15'h7C00)
         return (a[15] == b[15]) ? a : DefaultNan;
      if (a[14:0] == 15'h7C00) return a;
      if (b[14:0] == 15'h7C00) return b;
      ma = h_mag(a);
      mb = h_mag(b);
      sgn = a[15];
      if (a[15] == b[15]) mag = ma + mb;
      else if (ma >= mb) mag = ma - mb;
      else begin
         mag = mb - ma;
         sgn = b[15];
      end
      if (mag == 0) return {a[15] & b[15], 15'd0};
      if (mag < 1024) return {sgn, 5'd0, mag[9:0]};
      p = 0;
      for (int i = 0; i < 63; i++) if (mag[i]) p = i;
      sh = p - 10;
      q = mag >> sh;
      if (sh > 0) begin
         rem = mag & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q++;
         if (q == 2048) begin
            q = q >> 1;
            sh++;
         end
      end
      if (sh + 1 >= 31) return {sgn, 15'h7C00};
      return {sgn, 5'(sh + 1), q[9:0]};
   endfunction

   function automatic int h_key(input logic [15:0] h);
      return h[15] ? -int'(h[14:0]) - 1 : int'(h[14:0]);
   endfunction

   // predict one data element and advance the channel position
   function automatic elem_out_type biased_elem(input logic [15:0] val);
      elem_out_type o;
      int unsigned eff;
      logic [15:0] r;
      eff = (chan_copy == 0 || chan_copy > NumSlots) ? NumSlots : chan_copy;
      r = h_add(val, bias_copy[pos_copy]);
      if (act_copy == ACT_RELU || act_copy == ACT_CLIP) begin
         if (!h_nan(r) && r[15]) r = 16'h0000;
         if (act_copy == ACT_CLIP) begin
            if (h_nan(r)) r = r | 16'h0200;
            else if (h_nan(clip_copy)) r = clip_copy | 16'h0200;
            else if (h_key(clip_copy) < h_key(r)) r = clip_copy;
         end
      end
      o.result = r;
      o.end_of_row = (pos_copy + 1 >= eff);
      pos_copy = o.end_of_row ? 0 : pos_copy + 1;
      return o;
   endfunction

   // interesting fp16 patterns mixed with plain random ones
   function automatic logic [15:0] pick_half();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(0, 9))
         0: v = {v[15], 15'h7C00};
         1: v = {v[15], 5'h1F, v[9:0] | 10'h001};
         2: v = {v[15], 15'd0};
         3: v = {v[15], 5'd0, v[9:0]};
         4: v = {v[15], 5'h1E, v[9:0]};
         5: v = {v[15], 5'(14 + $urandom_range(0, 2)), v[9:0]};
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pack_item(input cmd_type c, input logic [9:0] idx,
                                             input logic [15:0] val);
      return {5'd0, val, idx, c};
   endfunction

   // push a data element, loading its slot first if it was never written
   task automatic gen_element(input logic [15:0] val, input int unsigned chans);
      int unsigned eff;
      eff = (chans == 0 || chans > NumSlots) ? NumSlots : chans;
      if (!slot_loaded[gen_pos]) begin
         pending_items.push_back(pack_item(CMD_LOAD, 10'(gen_pos), pick_half()));
         slot_loaded[gen_pos] = 1'b1;
      end
      pending_items.push_back(pack_item(CMD_DATA, 10'($urandom), val));
      gen_pos = (gen_pos + 1 >= eff) ? 0 : gen_pos + 1;
   endtask

   task automatic gen_load(input logic [9:0] idx, input logic [15:0] val);
      pending_items.push_back(pack_item(CMD_LOAD, idx, val));
      slot_loaded[idx] = 1'b1;
   endtask

   task automatic write_reg(input reg_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_ACT_MODE: act_copy = activation_type'(val[1:0]);
         REG_CLIP:     clip_copy = val;
         REG_CHANNELS: chan_copy = val[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_all();
      wait (pending_items.size() == 0 && !req_tvalid && expected_elems.size() == 0);
      repeat (Latency) @(posedge clock);
   endtask

   // request side handshake and prediction
   bit req_fire;
   always @(posedge clock) begin
      req_fire = req_tvalid && req_tready && !reset;
      if (req_fire) begin
         if (cmd_type'(req_tdata[0]) == CMD_LOAD) bias_copy[req_tdata[10:1]] = req_tdata[26:11];
         else expected_elems.push_back(biased_elem(req_tdata[26:11]));
      end
   end

   // driver: bursts of transactions with random gaps
   int burst_left = 4;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (send_pause || pending_items.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_items.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: own stall pattern plus occasional long hold-off
   int hold_served = 0;
   int hold_left = 0;
   int run_left = 0;
   bit run_ready = 1'b1;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         if (run_left <= 0) begin
            run_ready = $urandom_range(0, 2) != 0;
            run_left = run_ready ? $urandom_range(1, 40) : $urandom_range(1, 5);
         end
         run_left--;
         rsp_tready <= run_ready;
      end
   end

   // monitor: compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      elem_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_elems.size() == 0) begin
            $error("unexpected result transaction 0x%h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_elems.pop_front();
            if (rsp_tdata[15:0] !== want.result) begin
               $error("result: expected 0x%h actual 0x%h", want.result, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[16] !== want.end_of_row) begin
               $error("end_of_row: expected %0d actual %0d", want.end_of_row, rsp_tdata[16]);
               error_count++;
            end
         end
      end
   end

   // watchdog on stalled progress
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_items.size() == 0 && !req_tvalid && expected_elems.size() == 0))
         idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // stimulus phases
   initial begin
      logic [15:0] clips[6];
      int unsigned chans[7];
      clips = '{16'h0000, 16'h8000, 16'h7C00, 16'h7E00, 16'hFBFF, 16'h3C00};
      chans = '{1, 1024, 0, 3, 8, 2047, 37};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_ACT_MODE;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: special sums with no activation over four channels, then clipped
      write_reg(REG_CHANNELS, 16'd4);
      write_reg(REG_UNUSED, 16'hFFFF);
      gen_load(10'd0, 16'h8000);
      gen_load(10'd1, 16'hFC00);
      gen_load(10'd2, 16'h7D01);
      gen_load(10'd3, 16'h7BFF);
      gen_load(10'h3FF, 16'h3C00);
      gen_element(16'h8000, 4);   // -0 + -0
      gen_element(16'h7C00, 4);   // inf - inf
      gen_element(16'hFE01, 4);   // data nan beats bias nan
      gen_element(16'h7BFF, 4);   // overflow
      gen_element(16'h0000, 4);   // +0 + -0
      gen_element(16'h7C01, 4);
      gen_element(16'h0001, 4);
      gen_element(16'hFBFF, 4);
      drain_all();
      write_reg(REG_ACT_MODE, 16'(ACT_CLIP));
      write_reg(REG_CLIP, 16'h7E00);
      gen_element(16'h3C00, 4);
      gen_element(16'h3C00, 4);
      gen_element(16'hFFFF, 4);
      gen_element(16'h0400, 4);
      drain_all();
      write_reg(REG_CLIP, ClipReset);
      gen_element(16'h4000, 4);
      gen_element(16'h4500, 4);
      gen_element(16'hC000, 4);
      gen_element(16'h4000, 4);
      drain_all();

      // random phases
      for (int ph = 0; ph < 12; ph++) begin
         int unsigned ch;
         activation_type md;
         md = activation_type'(ph % 4);
         ch = chans[ph % 7];
         write_reg(REG_ACT_MODE, 16'(md));
         write_reg(REG_CLIP, ($urandom_range(0, 1) == 0) ? clips[ph % 6] : pick_half());
         write_reg(REG_CHANNELS, 16'(ch));
         if (ph == 5) hold_requests++;
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(0, 9) == 0) gen_load(10'($urandom), pick_half());
            gen_element(pick_half(), ch);
         end
         drain_all();
         if (ph == 8) begin
            send_pause = 1'b1;
            repeat (20) @(posedge clock);
            send_pause = 1'b0;
         end
      end

      drain_all();
      if (error_count == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule

/* sim.f */
src/fpba_pkg.sv
src/fpba_ram.sv
src/fpba_front.sv
src/fpba_back.sv
src/fp16_bias_add_activation.sv
sim/testbench.sv
